[sv/assert_macros.svh]
// Assertion helpers used by okl_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define OKL_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define OKL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");

`endif

[sv/okl_pkg.sv]
package okl_pkg;

	localparam int KEY_W = 32;
	localparam int MODE_W = 3;
	localparam int POS_W = 5;
	localparam int STATUS_W = 2;
	localparam int FOUND_W = 4;
	localparam int COUNT_W = 5;

	// Request codes.
	typedef enum logic [MODE_W-1:0] {
		MODE_INS_HEAD = 3'd0,
		MODE_INS_TAIL = 3'd1,
		MODE_INS_POS  = 3'd2,
		MODE_REMOVE   = 3'd3,
		MODE_SEARCH   = 3'd4
	} mode_t;

	// Result status codes.
	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_MISSING = 2'd2,
		STAT_BADPOS  = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SHIFT_UP,
		ST_SHIFT_DN,
		ST_DRAIN,
		ST_PUT,
		ST_RESP
	} state_t;

	// Strobes from the sequencer to the key memory.
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} ram_ctl_t;

endpackage

[sv/okl_ram.sv]
module okl_ram #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  logic                      clk,
	input  okl_pkg::ram_ctl_t         ctl,
	input  logic [AW-1:0]             wr_addr,
	input  logic signed [okl_pkg::KEY_W-1:0] wr_data,
	input  logic [AW-1:0]             rd_addr,
	output logic signed [okl_pkg::KEY_W-1:0] rd_data
);
	import okl_pkg::*;

	logic signed [KEY_W-1:0] mem [DEPTH];
	logic signed [KEY_W-1:0] rd_data_q;

	// One write port.
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// One registered read port.
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

[sv/okl_ctrl.sv]
`include "assert_macros.svh"

module okl_ctrl #(
	parameter int CAPACITY = 16,
	parameter int IW = 4,
	parameter int CW = 5
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [okl_pkg::MODE_W-1:0]    mode,
	input  logic signed [okl_pkg::KEY_W-1:0] key,
	input  logic [okl_pkg::POS_W-1:0]     insert_position,
	output logic                          busy,
	output logic                          done,
	output logic [okl_pkg::STATUS_W-1:0]  status,
	output logic signed [okl_pkg::KEY_W-1:0] removed_key,
	output logic [okl_pkg::FOUND_W-1:0]   found_index,
	output logic [okl_pkg::COUNT_W-1:0]   entry_count,
	output okl_pkg::ram_ctl_t             ram_ctl,
	output logic [IW-1:0]                 wr_addr,
	output logic signed [okl_pkg::KEY_W-1:0] wr_data,
	output logic [IW-1:0]                 rd_addr,
	input  logic signed [okl_pkg::KEY_W-1:0] rd_data
);
	import okl_pkg::*;

	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	state_t                  state_q, state_d;
	logic [MODE_W-1:0]       mode_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [KEY_W-1:0] removed_q;
	status_t                 status_q;
	logic [IW-1:0]           found_q;
	logic [CW-1:0]           occ_q;
	logic [IW-1:0]           tgt_q;
	logic [IW-1:0]           cur_q;
	logic                    more_q;
	logic                    rv_s1;
	logic [IW-1:0]           ridx_s1;

	logic                    accept;
	logic                    is_insert;
	logic                    is_lookup;
	logic                    full;
	logic                    bad_pos;
	logic [CW-1:0]           put_pos;
	logic [IW-1:0]           last;
	logic                    hit;
	logic                    scan_end;
	logic                    is_remove_q;

	assign accept = start && (state_q == ST_IDLE);
	assign is_insert = (mode == MODE_INS_HEAD) || (mode == MODE_INS_TAIL)
		|| (mode == MODE_INS_POS);
	assign is_lookup = (mode == MODE_REMOVE) || (mode == MODE_SEARCH);
	assign full = (occ_q == CW'(CAPACITY));
	assign bad_pos = (mode == MODE_INS_POS) && (CMPW'(insert_position) > CMPW'(occ_q));
	assign last = IW'(occ_q - CW'(1));
	assign is_remove_q = (mode_q == MODE_REMOVE);

	// Shared key comparator on the registered memory read.
	assign hit = rv_s1 && (rd_data == key_q);
	assign scan_end = rv_s1 && (hit || (ridx_s1 == last));

	// Insert position for the accepted request.
	always_comb begin
		priority if (mode == MODE_INS_HEAD) begin
			put_pos = '0;
		end else if (mode == MODE_INS_TAIL) begin
			put_pos = occ_q;
		end else begin
			put_pos = CW'(insert_position);
		end
	end

	// Next-state logic.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (is_insert) begin
						if (full || bad_pos) begin
							state_d = ST_RESP;
						end else if (put_pos == occ_q) begin
							state_d = ST_PUT;
						end else begin
							state_d = ST_SHIFT_UP;
						end
					end else if (is_lookup && (occ_q != '0)) begin
						state_d = ST_SCAN;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					if (hit && is_remove_q && (ridx_s1 != last)) begin
						state_d = ST_SHIFT_DN;
					end else begin
						state_d = ST_RESP;
					end
				end
			end
			ST_SHIFT_UP: begin
				if (cur_q == tgt_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_SHIFT_DN: begin
				if (cur_q == last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = is_remove_q ? ST_RESP : ST_PUT;
			end
			ST_PUT: begin
				state_d = ST_RESP;
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Memory strobes and addresses.
	always_comb begin
		ram_ctl = '0;
		rd_addr = cur_q;
		wr_addr = tgt_q;
		wr_data = rd_data;
		unique case (state_q)
			ST_SCAN: begin
				ram_ctl.rd_en = more_q && !scan_end;
			end
			ST_SHIFT_UP: begin
				ram_ctl.rd_en = 1'b1;
				ram_ctl.wr_en = rv_s1;
				wr_addr = ridx_s1 + IW'(1);
			end
			ST_SHIFT_DN: begin
				ram_ctl.rd_en = 1'b1;
				ram_ctl.wr_en = rv_s1;
				wr_addr = ridx_s1 - IW'(1);
			end
			ST_DRAIN: begin
				ram_ctl.wr_en = 1'b1;
				wr_addr = is_remove_q ? (ridx_s1 - IW'(1)) : (ridx_s1 + IW'(1));
			end
			ST_PUT: begin
				ram_ctl.wr_en = 1'b1;
				wr_data = key_q;
			end
			default: begin
				ram_ctl = '0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			occ_q <= '0;
			rv_s1 <= 1'b0;
			more_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rv_s1 <= ram_ctl.rd_en;
			if (state_q == ST_IDLE) begin
				more_q <= 1'b1;
			end else if ((state_q == ST_SCAN) && ram_ctl.rd_en) begin
				more_q <= (cur_q != last);
			end
			if ((state_q == ST_PUT)
				|| ((state_q == ST_DRAIN) && is_remove_q)
				|| ((state_q == ST_SCAN) && hit && is_remove_q && (ridx_s1 == last))) begin
				occ_q <= (state_q == ST_PUT) ? (occ_q + CW'(1)) : (occ_q - CW'(1));
			end
		end
	end

	// Request and result payload registers.
	always_ff @(posedge clk) begin
		if (ram_ctl.rd_en) begin
			ridx_s1 <= cur_q;
		end
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					mode_q <= mode;
					key_q <= key;
					removed_q <= '0;
					found_q <= '0;
					tgt_q <= IW'(put_pos);
					cur_q <= is_insert ? last : '0;
					if (is_insert && full) begin
						status_q <= STAT_FULL;
					end else if (is_insert && bad_pos) begin
						status_q <= STAT_BADPOS;
					end else if (is_lookup && (occ_q == '0)) begin
						status_q <= STAT_MISSING;
					end else begin
						status_q <= STAT_OK;
					end
				end
			end
			ST_SCAN: begin
				if (ram_ctl.rd_en) begin
					cur_q <= cur_q + IW'(1);
				end
				if (hit) begin
					if (is_remove_q) begin
						removed_q <= key_q;
						cur_q <= ridx_s1 + IW'(1);
					end else begin
						found_q <= ridx_s1;
					end
				end else if (scan_end) begin
					status_q <= STAT_MISSING;
				end
			end
			ST_SHIFT_UP: begin
				cur_q <= cur_q - IW'(1);
			end
			ST_SHIFT_DN: begin
				cur_q <= cur_q + IW'(1);
			end
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_RESP);
	assign status = status_q;
	assign removed_key = removed_q;
	assign found_index = FOUND_W'(found_q);
	assign entry_count = COUNT_W'(occ_q);

	// The count never passes the capacity.
	`OKL_ASSERT_NOW(a_occ_bound, clk, arst_n, 1'b1, occ_q <= CW'(CAPACITY))
	// The count only moves on the way into a result cycle.
	`OKL_ASSERT_NOW(a_occ_moves_at_resp, clk, arst_n, !$stable(occ_q), state_q == ST_RESP)
	// A full status is given only with a full list.
	`OKL_ASSERT_NOW(a_full_status, clk, arst_n, done && (status_q == STAT_FULL),
		occ_q == CW'(CAPACITY))
	// The memory is never written outside a request.
	`OKL_ASSERT_NOW(a_no_idle_write, clk, arst_n, ram_ctl.wr_en,
		(state_q != ST_IDLE) && (state_q != ST_RESP))
	// An accepted request always leaves idle.
	`OKL_ASSERT_NEXT(a_accept_busy, clk, arst_n, accept, busy)

endmodule

[sv/ordered_key_list_engine.sv]
// Ordered key list: one request per transfer, one result strobe per request.
// Requests that touch no entry go straight to the result state; an insert at the end
// writes the key first, and a remove walks and shifts the key memory before the result.
// The walk and the shift move one entry a cycle; busy falls the cycle after done,
// so a new request is taken only once the last one is finished. The receiver cannot stall.
// Reset (arst_n low) empties the list at once; key memory is not cleared.
module ordered_key_list_engine #(
	parameter int CAPACITY = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [okl_pkg::MODE_W-1:0]       mode,
	input  logic signed [okl_pkg::KEY_W-1:0] key,
	input  logic [okl_pkg::POS_W-1:0]        insert_position,
	output logic                             busy,
	output logic                             done,
	output logic [okl_pkg::STATUS_W-1:0]     status,
	output logic signed [okl_pkg::KEY_W-1:0] removed_key,
	output logic [okl_pkg::FOUND_W-1:0]      found_index,
	output logic [okl_pkg::COUNT_W-1:0]      entry_count
);
	import okl_pkg::*;

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	ram_ctl_t                ram_ctl;
	logic [IW-1:0]           wr_addr;
	logic [IW-1:0]           rd_addr;
	logic signed [KEY_W-1:0] wr_data;
	logic signed [KEY_W-1:0] rd_data;

	// Sequencer with the shared comparator and index counter.
	okl_ctrl #(
		.CAPACITY(CAPACITY),
		.IW(IW),
		.CW(CW)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.mode(mode),
		.key(key),
		.insert_position(insert_position),
		.busy(busy),
		.done(done),
		.status(status),
		.removed_key(removed_key),
		.found_index(found_index),
		.entry_count(entry_count),
		.ram_ctl(ram_ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

	// Key storage in list order.
	okl_ram #(
		.DEPTH(CAPACITY),
		.AW(IW)
	) u_ram (
		.clk(clk),
		.ctl(ram_ctl),
		.wr_addr(wr_addr),
		.wr_data(wr_data),
		.rd_addr(rd_addr),
		.rd_data(rd_data)
	);

endmodule
